FILE: design/sfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfm_pkg;

	// Default sizes for the top level parameters
	localparam int MAX_PATTERN_DEF   = 32;
	localparam int POSITION_BITS_DEF = 32;

	// Fixed field widths
	localparam int LEN_W  = 6;
	localparam int SLOT_W = 5;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 32;

	// Item kinds
	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic [BYTE_W-1:0] byte_value;
		logic              last;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} result_t;

	// Per-cell controls
	typedef struct packed {
		logic win_shift;  // accept a text byte into the window
		logic pat_shift;  // realign: take pattern byte from neighbor
		logic pat_we;     // direct pattern byte write
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/sfm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/sfm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One window position: holds a text byte and the pattern byte aligned to it.
module sfm_cell (
	input  logic                      clk,
	input  sfm_pkg::cell_ctl_t        ctl,
	input  logic [sfm_pkg::BYTE_W-1:0] win_in,
	input  logic [sfm_pkg::BYTE_W-1:0] pat_in,
	input  logic [sfm_pkg::BYTE_W-1:0] pat_wdata,
	output logic [sfm_pkg::BYTE_W-1:0] win_out,
	output logic [sfm_pkg::BYTE_W-1:0] pat_out,
	output logic                      eq
);
	import sfm_pkg::*;

	logic [BYTE_W-1:0] win_q;
	logic [BYTE_W-1:0] pat_q;

	always_ff @(posedge clk) begin
		if (ctl.win_shift) begin
			win_q <= win_in;
		end
		if (ctl.pat_shift) begin
			pat_q <= pat_in;
		end else if (ctl.pat_we) begin
			pat_q <= pat_wdata;
		end
	end

	// compare against the byte that lands here on this transfer
	assign eq      = (win_in == pat_q);
	assign win_out = win_q;
	assign pat_out = pat_q;

endmodule

`default_nettype wire

FILE: design/substring_first_match.sv
// A result is registered into the head register, or into the skid entry while the head
// waits, from the text byte that causes it. Throughput: one item per cycle while the input
// is not stalled; input stalls while the skid entry holds a result or a realign runs.
// A pattern_length write realigns the cell pattern bytes from the pattern RAM, one slot
// per cycle: input stalls until the last slot read from the RAM is shifted into the cells.
// Reset (arst_n low, async): counter 0 (window bytes not cleared), no match, pattern_length 1;
// pattern bytes are undefined until loaded, there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module substring_first_match #(
	parameter int MAX_PATTERN   = sfm_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = sfm_pkg::POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item channel
	input  logic                      item_valid,
	output logic                      item_stall,
	input  sfm_pkg::item_t            item,
	// result channel
	output logic                      result_valid,
	input  logic                      result_stall,
	output sfm_pkg::result_t          result,
	// pattern_length register
	input  logic                      cfg_wen,
	input  logic [sfm_pkg::LEN_W-1:0] cfg_wdata
);
	import sfm_pkg::*;

	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int CW = (LW > LEN_W) ? LW : LEN_W;
	localparam int MW = POSITION_BITS + CW;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	logic [LW-1:0]            len_q;       // clamped pattern length, 1..MAX_PATTERN
	logic                     busy_q;      // realign reads in flight
	logic [AW-1:0]            rd_cnt_q;    // realign read address
	logic                     rd_vld_s1;   // RAM read data valid this cycle
	logic                     reported_q;  // match already given in this stream
	logic [POSITION_BITS-1:0] count_q;     // text bytes seen in this stream (saturating)

	// output buffer: head register plus skid entry
	result_t res_q;
	logic    res_vld_q;
	result_t skid_q;
	logic    skid_vld_q;

	// ------------------------------------------------------------------
	// Item transfer decode
	// ------------------------------------------------------------------
	logic acc;
	logic is_text;
	logic is_pat;
	logic live;

	assign item_stall = busy_q | rd_vld_s1 | skid_vld_q;
	assign acc        = item_valid & ~item_stall;
	assign is_text    = acc & (item.kind == KIND_TEXT);
	assign is_pat     = acc & (item.kind == KIND_PATTERN);
	// a text byte after the match is only watched for last
	assign live       = is_text & ~reported_q;

	// ------------------------------------------------------------------
	// Length clamp on register write: 0 acts as 1, above depth acts as depth
	// ------------------------------------------------------------------
	logic [CW-1:0] wdata_ext;
	logic [LW-1:0] len_clamp;

	always_comb begin
		wdata_ext = CW'(cfg_wdata);
		priority if (wdata_ext == '0) begin
			len_clamp = LW'(1);
		end else if (wdata_ext > CW'(MAX_PATTERN)) begin
			len_clamp = LW'(MAX_PATTERN);
		end else begin
			len_clamp = wdata_ext[LW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Pattern RAM (slot order) and realign sequencer.
	// Cell i holds pattern slot len-1-i, so each cell compares against the
	// window byte at its own position. After a length change the cells are
	// refilled by shifting slots 0..len-1 in at cell 0.
	// ------------------------------------------------------------------
	logic [CW-1:0]     slot_ext;
	logic [CW-1:0]     len_ext;
	logic [CW-1:0]     tgt;
	logic              slot_in_len;
	logic              ram_we;
	logic [BYTE_W-1:0] ram_rdata;
	logic              rd_last;

	assign slot_ext    = CW'(item.slot);
	assign len_ext     = CW'(len_q);
	assign tgt         = len_ext - CW'(1) - slot_ext;
	assign slot_in_len = slot_ext < len_ext;
	assign ram_we      = is_pat & (slot_ext < CW'(MAX_PATTERN));
	assign rd_last     = (LW'(rd_cnt_q) == (len_q - LW'(1)));

	sfm_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PATTERN)
	) u_pat_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(item.slot)),
		.wdata (item.byte_value),
		.raddr (rd_cnt_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LW'(1);
			busy_q    <= 1'b0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= busy_q;
			if (cfg_wen) begin
				len_q    <= len_clamp;
				busy_q   <= 1'b1;
				rd_cnt_q <= '0;
			end else if (busy_q) begin
				if (rd_last) begin
					busy_q <= 1'b0;
				end else begin
					rd_cnt_q <= rd_cnt_q + AW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Cell chain: window shifts from cell 0 upward, newest byte at cell 0
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0] win_out [MAX_PATTERN];
	logic [BYTE_W-1:0] pat_out [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;
	logic [MAX_PATTERN-1:0] in_len;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		cell_ctl_t         ctl;
		logic [BYTE_W-1:0] win_in;
		logic [BYTE_W-1:0] pat_in;

		if (i == 0) begin : g_head
			assign win_in = item.byte_value;
			assign pat_in = ram_rdata;
		end else begin : g_body
			assign win_in = win_out[i-1];
			assign pat_in = pat_out[i-1];
		end

		assign ctl.win_shift = live;
		assign ctl.pat_shift = rd_vld_s1;
		assign ctl.pat_we    = is_pat & slot_in_len & (tgt == CW'(i));
		assign in_len[i]     = CW'(i) < len_ext;

		sfm_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.win_in    (win_in),
			.pat_in    (pat_in),
			.pat_wdata (item.byte_value),
			.win_out   (win_out[i]),
			.pat_out   (pat_out[i]),
			.eq        (eq[i])
		);
	end

	// ------------------------------------------------------------------
	// Match decision for the byte in transfer
	// ------------------------------------------------------------------
	logic                       all_eq;
	logic                       enough;
	logic                       hit;
	logic                       produce;
	logic [POSITION_BITS-1:0]   diff;
	logic [POSITION_BITS+POS_W-1:0] diff_ext;
	result_t                    res_new;

	assign all_eq   = &(eq | ~in_len);
	// need len bytes of this stream in the window
	assign enough   = MW'(count_q) >= (MW'(len_q) - MW'(1));
	assign hit      = live & enough & all_eq;
	assign produce  = hit | (live & item.last);
	assign diff     = count_q - POSITION_BITS'(len_q - LW'(1));
	assign diff_ext = {{POS_W{1'b0}}, diff};

	always_comb begin
		res_new.found    = hit;
		res_new.position = hit ? diff_ext[POS_W-1:0] : '0;
	end

	// stream state: last ends the stream, matched or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
			count_q    <= '0;
		end else if (is_text) begin
			if (item.last) begin
				reported_q <= 1'b0;
				count_q    <= '0;
			end else begin
				if (hit) begin
					reported_q <= 1'b1;
				end
				if (live && (count_q != '1)) begin
					count_q <= count_q + POSITION_BITS'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output buffer; skid entry fills only while head waits
	// ------------------------------------------------------------------
	logic pop;

	assign pop = res_vld_q & ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			priority if (skid_vld_q) begin
				if (pop) begin
					res_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (!res_vld_q || pop) begin
				res_vld_q <= produce;
			end else if (produce) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_vld_q) begin
			if (pop) begin
				res_q <= skid_q;
			end
		end else if (!res_vld_q || pop) begin
			if (produce) begin
				res_q <= res_new;
			end
		end else if (produce) begin
			skid_q <= res_new;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> res_vld_q)
		else $error("skid entry held with empty head");

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> item_stall)
		else $error("input open right after length write");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) && (len_q <= LW'(MAX_PATTERN)))
		else $error("pattern length out of range");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !res_q.found) |-> (res_q.position == '0))
		else $error("no-match result carries a position");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '1 && live && !item.last) |=> (count_q == '1))
		else $error("byte counter wrapped");

	a_one_per_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(hit && !item.last) |=> reported_q)
		else $error("match not recorded");

endmodule

`default_nettype wire

FILE: tb/sv/substring_first_match_test.sv
`timescale 1ns / 1ps

module substring_first_match_test;
	import sfm_pkg::*;

	localparam int WIN_DEPTH      = 32;
	localparam int IDLE_PCT       = 26;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASE_ITEMS    = 100;

	// DUT connections, all inputs known from time zero
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	item_t                item_bus     = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result_bus;
	logic                 cfg_wen      = 1'b0;
	logic [LEN_W-1:0]     cfg_wdata    = '0;

	// Search state mirrored by the testbench (updated on each accepted transfer)
	bit [BYTE_W-1:0]      pat_mem [WIN_DEPTH];
	bit [BYTE_W-1:0]      win [WIN_DEPTH];   // index 0 holds the newest text byte
	bit [POS_W-1:0]       seen_count;
	bit                   matched;
	bit [LEN_W-1:0]       len_reg = 6'd1;

	// Stimulus planning state (runs ahead of the DUT)
	bit [BYTE_W-1:0]      plan_pat [WIN_DEPTH];
	int                   plan_len = 1;

	item_t                item_backlog [$];
	result_t              due_results [$];
	int                   miscompares = 0;

	// Traffic shaping flags, written by the stimulus process (squeeze_cnt by the monitor)
	bit                   no_gaps = 1'b0;
	bit                   squeeze_armed = 1'b0;
	int                   squeeze_cnt = 0;

	int                   len_plan [15] = '{1, 2, 0, 3, 5, 8, 13, 63, 16, 24, 31, 32, 33, 4, 2};

	substring_first_match uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Closes out the current text stream: window cleared, offset restarts.
	task automatic close_stream();
		for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
		seen_count = '0;
		matched    = 1'b0;
	endtask

	// Predicts the effect of one accepted item; queues a result when one is due.
	task automatic search_step(input item_t it);
		int              eff;
		bit              hit;
		bit [POS_W-1:0]  offs;
		result_t         r;
		if (it.kind == KIND_PATTERN) begin
			// slot field cannot exceed the store depth; last is don't-care here
			pat_mem[it.slot] = it.byte_value;
		end else if (matched) begin
			// stream already answered: bytes dropped until last
			if (it.last) close_stream();
		end else begin
			for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
			win[0] = it.byte_value;
			offs = seen_count;
			if (seen_count != '1) seen_count++;   // saturating byte counter
			// length 0 acts as 1, anything past the window acts as full width
			eff = (len_reg == 0) ? 1 : ((len_reg > WIN_DEPTH) ? WIN_DEPTH : int'(len_reg));
			hit = (offs >= eff - 1);   // not enough bytes yet -> no match
			for (int k = 0; k < eff; k++)
				if (pat_mem[k] != win[eff-1-k]) hit = 1'b0;
			if (hit) begin
				r.found    = 1'b1;
				r.position = offs - POS_W'(eff - 1);
				due_results.push_back(r);
				// a match on the last byte gives only the found result
				if (it.last) close_stream();
				else matched = 1'b1;
			end else if (it.last) begin
				r.found    = 1'b0;
				r.position = '0;
				due_results.push_back(r);
				close_stream();
			end
		end
	endtask

	// Driver: holds the payload while stalled, otherwise pulls from the backlog
	// or idles at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) search_step(item_bus);
			if (!item_valid || !item_stall) begin
				if (item_backlog.size() > 0 &&
				    (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
					item_bus   <= item_backlog.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest prediction and
	// drives the result stall. The long hold-off is counted here so the sender
	// keeps pushing while the output side is blocked.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					if (miscompares < REPORT_LIMIT)
						$display("unexpected result: found=%0b position=%0d",
						         result_bus.found, result_bus.position);
					miscompares++;
				end else begin
					want = due_results.pop_front();
					if (result_bus.found !== want.found ||
					    result_bus.position !== want.position) begin
						if (miscompares < REPORT_LIMIT)
							$display("result mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
							         want.found, want.position,
							         result_bus.found, result_bus.position);
						miscompares++;
					end
				end
			end
			if (squeeze_armed && squeeze_cnt < SQUEEZE_CYCLES) begin
				squeeze_cnt  <= squeeze_cnt + 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	task automatic push_pattern(input int s, input bit [BYTE_W-1:0] b, input bit lst);
		item_t it;
		it.kind       = KIND_PATTERN;
		it.slot       = SLOT_W'(s);
		it.byte_value = b;
		it.last       = lst;
		plan_pat[s]   = b;
		item_backlog.push_back(it);
	endtask

	task automatic push_text(input bit [BYTE_W-1:0] b, input bit lst);
		item_t it;
		it.kind       = KIND_TEXT;
		it.slot       = SLOT_W'($urandom_range(0, WIN_DEPTH - 1));   // unused on text bytes
		it.byte_value = b;
		it.last       = lst;
		item_backlog.push_back(it);
	endtask

	// Wait until every item is sent and every result is back, then let the
	// pipeline settle (items that produce nothing may still be in flight).
	task automatic wait_drained();
		while (item_backlog.size() > 0 || item_valid || due_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, only issued with the block idle.
	task automatic write_length(input int v);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= LEN_W'(v);
		@(posedge clk);
		cfg_wen   <= 1'b0;
		len_reg   = LEN_W'(v);
		plan_len  = (v == 0) ? 1 : ((v > WIN_DEPTH) ? WIN_DEPTH : v);
	endtask

	// Random traffic for one length setting: mostly whole streams over a small
	// per-phase alphabet with the pattern planted in half of the streams long enough to hold it,
	// mixed with pattern reloads, stray slot writes and the odd unterminated stream.
	task automatic gen_phase(input int budget, input bit dense);
		int              made;
		int              r;
		int              n;
		int              at;
		bit              plant;
		bit [BYTE_W-1:0] alpha [4];
		bit [BYTE_W-1:0] b;
		made = 0;
		for (int i = 0; i < 4; i++) alpha[i] = BYTE_W'($urandom_range(0, 255));
		for (int s = 0; s < plan_len; s++)
			push_pattern(s, alpha[$urandom_range(0, 3)], 1'($urandom_range(0, 1)));
		while (made < budget) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				for (int s = 0; s < plan_len; s++)
					push_pattern(s, alpha[$urandom_range(0, 3)], 1'($urandom_range(0, 1)));
				made += plan_len;
			end else if (r < 14) begin
				push_pattern($urandom_range(0, WIN_DEPTH - 1),
				             BYTE_W'($urandom_range(0, 255)),
				             1'($urandom_range(0, 1)));
				made++;
			end else begin
				n     = dense ? $urandom_range(1, 3) : $urandom_range(1, 2 * plan_len + 6);
				plant = (n >= plan_len) && ($urandom_range(0, 1) == 1);
				at    = plant ? $urandom_range(0, n - plan_len) : 0;
				for (int j = 0; j < n; j++) begin
					if (plant && j >= at && j < at + plan_len) b = plan_pat[j-at];
					else if ($urandom_range(0, 9) == 0) b = BYTE_W'($urandom_range(0, 255));
					else b = alpha[$urandom_range(0, 3)];
					// rare pattern rewrite inside a stream
					if ($urandom_range(0, 49) == 0)
						push_pattern($urandom_range(0, WIN_DEPTH - 1),
						             alpha[$urandom_range(0, 3)], 1'b0);
					// the final byte usually ends the stream; sometimes it stays open
					push_text(b, (j == n - 1) && ($urandom_range(0, 19) != 0));
				end
				made += n;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Every slot gets a value before any text byte is compared.
		for (int s = 0; s < WIN_DEPTH; s++)
			push_pattern(s, (s == 0) ? 8'hFF : ((s == 1) ? 8'h00 : BYTE_W'(s * 37)), 1'b0);

		// Length 1 after reset, pattern byte 0xFF.
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b0);   // match at offset 1
		push_text(8'hFF, 1'b0);   // dropped, already matched
		push_text(8'h12, 1'b1);   // last after a match: silent
		push_text(8'h00, 1'b1);   // one-byte stream, no match
		push_text(8'hFF, 1'b1);   // match on the last byte
		push_pattern(31, 8'hAB, 1'b1);   // last on a pattern load is ignored

		// Length 0 behaves as 1.
		wait_drained();
		write_length(0);
		push_text(8'hFF, 1'b1);
		push_text(8'h01, 1'b0);
		push_text(8'h02, 1'b1);

		// Full-width pattern against a text that is too short.
		wait_drained();
		write_length(WIN_DEPTH);
		push_text(8'hFF, 1'b0);
		push_text(8'h00, 1'b0);
		push_text(8'h4A, 1'b1);

		// Pattern changed between two bytes of the same stream.
		wait_drained();
		write_length(2);
		push_pattern(0, 8'h41, 1'b0);
		push_pattern(1, 8'h42, 1'b0);
		push_text(8'h41, 1'b0);
		push_pattern(1, 8'h43, 1'b0);
		push_text(8'h43, 1'b1);

		// Oversized length clamps to the window depth.
		wait_drained();
		write_length(63);
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b1);

		for (int ph = 0; ph < 15; ph++) begin
			wait_drained();
			write_length(len_plan[ph]);
			no_gaps <= (ph == 5);
			// short streams here so results pile up behind the output hold-off
			if (ph == 1) squeeze_armed <= 1'b1;
			gen_phase(PHASE_ITEMS, ph == 1);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (miscompares == 0 && due_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

endmodule
